// ----- sv/mrft_pkg.sv -----
// Shared types and constants for the Manchester RF frame transmitter.
// No dependencies.
package mrft_pkg;

  // Offer kinds on the input channel
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_OFFER = 1'b1;

  // Pulse lengths, in 500 us units
  localparam logic [5:0] START_HIGH   = 6'd4;
  localparam logic [5:0] START_UNITS  = 6'd9;
  localparam logic [5:0] FINISH_HIGH  = 6'd6;
  localparam logic [5:0] FINISH_UNITS = 6'd12;

  localparam logic [7:0] PREAMBLE_BYTE = 8'hff;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic accepted;
    logic busy_res;
    logic frame_done;
  } result_t;

endpackage

// ----- sv/mrft_if.sv -----
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing.
interface mrft_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, kind, data_byte, last_byte, input ready);
  modport sink   (input valid, kind, data_byte, last_byte, output ready);
endinterface

interface mrft_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic accepted;
  logic busy_res;
  logic frame_done;

  modport source (output valid, line_level, accepted, busy_res, frame_done, input ready);
  modport sink   (input valid, line_level, accepted, busy_res, frame_done, output ready);
endinterface

// ----- sv/mrft_fsm.sv -----
// Frame sequencer: holding register, phase state and line level per transfer.
// Depends on mrft_pkg.
module mrft_fsm #(
  parameter int unsigned PREAMBLE_BYTES = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  mrft_pkg::item_t  item_i,
  output mrft_pkg::result_t res_o
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_PREAMBLE = 3'd1;
  localparam logic [2:0] PH_START    = 3'd2;
  localparam logic [2:0] PH_DATA     = 3'd3;
  localparam logic [2:0] PH_WAIT     = 3'd4;
  localparam logic [2:0] PH_FINISH   = 3'd5;

  localparam logic [5:0] PreCount = 6'(PREAMBLE_BYTES);

  logic [2:0] phase_q, phase_d;
  logic [5:0] unit_q, unit_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] hbi_q, hbi_d;
  logic [7:0] hold_byte_q, hold_byte_d;
  logic       hold_valid_q, hold_valid_d;
  logic       hold_last_q, hold_last_d;
  logic       cur_last_q, cur_last_d;
  logic       done;
  logic       acc;
  logic       level;
  logic [5:0] unit_inc;

  assign unit_inc = unit_q + 6'd1;

  always_comb begin
    phase_d      = phase_q;
    unit_d       = unit_q;
    shift_d      = shift_q;
    hbi_d        = hbi_q;
    hold_byte_d  = hold_byte_q;
    hold_valid_d = hold_valid_q;
    hold_last_d  = hold_last_q;
    cur_last_d   = cur_last_q;
    done         = 1'b0;
    acc          = 1'b0;

    if (item_i.kind == mrft_pkg::KIND_TICK) begin
      case (phase_q)
        PH_IDLE: begin
          if (hold_valid_q) begin
            unit_d = '0;
            hbi_d  = '0;
            if (PREAMBLE_BYTES > 0) begin
              shift_d = mrft_pkg::PREAMBLE_BYTE;
              phase_d = PH_PREAMBLE;
            end else begin
              phase_d = PH_START;
            end
          end
        end
        PH_PREAMBLE: begin
          hbi_d = hbi_q + 4'd1;
          if (hbi_q == 4'hf) begin
            unit_d = unit_inc;
            if (unit_inc >= PreCount) begin
              unit_d  = '0;
              phase_d = PH_START;
            end
          end
        end
        PH_START: begin
          unit_d = unit_inc;
          if (unit_inc >= mrft_pkg::START_UNITS) begin
            unit_d = '0;
            phase_d = PH_WAIT;
            if (hold_valid_q) begin
              shift_d      = hold_byte_q;
              cur_last_d   = hold_last_q;
              hold_valid_d = 1'b0;
              hbi_d        = '0;
              phase_d      = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          hbi_d = hbi_q + 4'd1;
          if (hbi_q == 4'hf) begin
            if (cur_last_q) begin
              unit_d  = '0;
              phase_d = PH_FINISH;
            end else if (hold_valid_q) begin
              shift_d      = hold_byte_q;
              cur_last_d   = hold_last_q;
              hold_valid_d = 1'b0;
              hbi_d        = '0;
            end else begin
              phase_d = PH_WAIT;
            end
          end
        end
        PH_WAIT: begin
          // underrun: line stays low until a byte is held
          if (hold_valid_q) begin
            shift_d      = hold_byte_q;
            cur_last_d   = hold_last_q;
            hold_valid_d = 1'b0;
            hbi_d        = '0;
            phase_d      = PH_DATA;
          end
        end
        PH_FINISH: begin
          unit_d = unit_inc;
          if (unit_inc >= mrft_pkg::FINISH_UNITS) begin
            unit_d     = '0;
            cur_last_d = 1'b0;
            phase_d    = PH_IDLE;
            done       = 1'b1;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end else if (!hold_valid_q) begin
      hold_byte_d  = item_i.data_byte;
      hold_last_d  = item_i.last_byte;
      hold_valid_d = 1'b1;
      acc          = 1'b1;
    end
  end

  // Level of the unit that starts with this transfer
  always_comb begin
    case (phase_d)
      PH_PREAMBLE,
      PH_DATA:   level = shift_d[3'd7 - hbi_d[3:1]] ^ hbi_d[0];
      PH_START:  level = unit_d < mrft_pkg::START_HIGH;
      PH_FINISH: level = unit_d < mrft_pkg::FINISH_HIGH;
      default:   level = 1'b0;
    endcase
  end

  assign res_o.line_level = level;
  assign res_o.accepted   = acc;
  assign res_o.busy_res   = phase_d != PH_IDLE;
  assign res_o.frame_done = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      unit_q       <= '0;
      shift_q      <= '0;
      hbi_q        <= '0;
      hold_valid_q <= 1'b0;
      hold_last_q  <= 1'b0;
      cur_last_q   <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      unit_q       <= unit_d;
      shift_q      <= shift_d;
      hbi_q        <= hbi_d;
      hold_valid_q <= hold_valid_d;
      hold_last_q  <= hold_last_d;
      cur_last_q   <= cur_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      hold_byte_q <= hold_byte_d;
    end
  end

endmodule

// ----- sv/mrft_out_stage.sv -----
// Result register between the sequencer and the output channel.
// Depends on mrft_pkg.
module mrft_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mrft_pkg::result_t res_i,
  input  logic              ready_i,
  output logic              free_o,
  output logic              valid_o,
  output mrft_pkg::result_t res_o
);

  logic              valid_q;
  mrft_pkg::result_t res_q;

  // Register can take a new result when empty or when draining this cycle
  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- sv/manchester_rf_frame_transmitter.sv -----
// Manchester RF frame transmitter: one result per input transfer.
// Latency: the result is registered and valid in the cycle after the input transfer.
// Throughput: one item per cycle while the result register is empty or drained; a result left untaken stalls input.
// Reset: asynchronous, active low; idle phase, empty holding register, no result.
// Depends on mrft_pkg, mrft_if, mrft_fsm and mrft_out_stage.
module manchester_rf_frame_transmitter #(
  parameter int unsigned PREAMBLE_BYTES = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrft_in_if.sink    in_i,
  mrft_out_if.source out_o
);

  mrft_pkg::item_t   item;
  mrft_pkg::result_t res_next;
  mrft_pkg::result_t res_reg;
  logic              free;
  logic              step;

  assign item.kind      = in_i.kind;
  assign item.data_byte = in_i.data_byte;
  assign item.last_byte = in_i.last_byte;

  assign in_i.ready = free;
  assign step       = in_i.valid && free;

  mrft_fsm #(
    .PREAMBLE_BYTES(PREAMBLE_BYTES)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item),
    .res_o  (res_next)
  );

  mrft_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .res_i   (res_next),
    .ready_i (out_o.ready),
    .free_o  (free),
    .valid_o (out_o.valid),
    .res_o   (res_reg)
  );

  assign out_o.line_level = res_reg.line_level;
  assign out_o.accepted   = res_reg.accepted;
  assign out_o.busy_res   = res_reg.busy_res;
  assign out_o.frame_done = res_reg.frame_done;

endmodule

// ----- sv/mrft_checker.sv -----
// Port-level checks for the Manchester RF frame transmitter, bound to the top.
// Depends on manchester_rf_frame_transmitter and mrft_if.
module mrft_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic line_level_i,
  input logic accepted_i,
  input logic busy_res_i,
  input logic frame_done_i
);

  // Each input transfer yields a result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("no result after input transfer");

  // A pending result that is not taken blocks new input
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while result stalled");

  // Frame end leaves the block idle with the line low
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> !busy_res_i && !line_level_i && !accepted_i)
    else $error("frame_done with busy, line high or byte taken");

  // Line is low whenever no frame is in progress
  a_idle_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !busy_res_i |-> !line_level_i)
    else $error("line high while idle");

endmodule

bind manchester_rf_frame_transmitter mrft_checker u_mrft_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .line_level_i (out_o.line_level),
  .accepted_i   (out_o.accepted),
  .busy_res_i   (out_o.busy_res),
  .frame_done_i (out_o.frame_done)
);
